>>> hw/rtl/lfmt_pkg.sv
`timescale 1ns / 1ps

package lfmt_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int COUNT_W     = 16;
  localparam int POS_W       = 32;
  localparam int DIST_W      = 18;
  localparam int USED_W      = 5;
  localparam int ENTRY_W     = 4;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CMP_W       = ((IDX_W > USED_W) ? IDX_W : USED_W) + 1;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 18;

  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [POS_W-1:0]   pos_t;
  typedef logic [DIST_W-1:0]  dist_t;
  typedef logic [USED_W-1:0]  used_t;
  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [CMP_W-1:0]   cmp_t;
  typedef logic [ENTRY_W-1:0] entry_t;

  localparam logic [1:0] OP_RECORD = 2'd0;
  localparam logic [1:0] OP_START  = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_QUERY_A   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUERY_C   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_QUERY_G   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_QUERY_T   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIST  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES   = 3'd5;

  localparam dist_t DEFAULT_MAX_DIST = 18'd50000;
  localparam used_t DEFAULT_ENTRIES  = 5'd10;

  typedef struct packed {
    logic [1:0] opcode;
    pos_t       position;
    count_t     count_a;
    count_t     count_c;
    count_t     count_g;
    count_t     count_t;
  } rec_t;

  typedef struct packed {
    entry_t entry_index;
    pos_t   match_position;
    dist_t  match_distance;
    logic   valid_res;
    logic   last;
  } res_t;

  typedef enum logic [1:0] {
    TOK_FILL,
    TOK_REPL,
    TOK_READ
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t kind;
    logic      done;
    idx_t      target;
    used_t     limit;
    dist_t     distance;
    pos_t      pos;
  } token_t;

endpackage

>>> hw/rtl/lfmt_dist.sv
`timescale 1ns / 1ps

module lfmt_dist (
  input  logic            clk,
  input  logic            load,
  input  lfmt_pkg::rec_t  rec,
  input  lfmt_pkg::count_t query_a,
  input  lfmt_pkg::count_t query_c,
  input  lfmt_pkg::count_t query_g,
  input  lfmt_pkg::count_t query_t,
  output lfmt_pkg::dist_t distance
);

  lfmt_pkg::count_t gap_a;
  lfmt_pkg::count_t gap_c;
  lfmt_pkg::count_t gap_g;
  lfmt_pkg::count_t gap_t;

  always_ff @(posedge clk) begin
    if (load) begin
      gap_a <= (rec.count_a >= query_a) ? rec.count_a - query_a : query_a - rec.count_a;
      gap_c <= (rec.count_c >= query_c) ? rec.count_c - query_c : query_c - rec.count_c;
      gap_g <= (rec.count_g >= query_g) ? rec.count_g - query_g : query_g - rec.count_g;
      gap_t <= (rec.count_t >= query_t) ? rec.count_t - query_t : query_t - rec.count_t;
    end
    distance <= lfmt_pkg::dist_t'(gap_a) + lfmt_pkg::dist_t'(gap_c)
              + lfmt_pkg::dist_t'(gap_g) + lfmt_pkg::dist_t'(gap_t);
  end

endmodule

>>> hw/rtl/lfmt_cell.sv
`timescale 1ns / 1ps

module lfmt_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  lfmt_pkg::idx_t    cell_index,
  input  lfmt_pkg::token_t  tok_in,
  input  logic              tok_in_valid,
  output lfmt_pkg::token_t  tok_out,
  output logic              tok_out_valid,
  output logic              emit,
  output lfmt_pkg::res_t    res
);

  lfmt_pkg::token_t tok_q;
  logic             tok_valid;
  lfmt_pkg::pos_t   slot_position;
  lfmt_pkg::dist_t  slot_distance;
  logic             in_use;
  logic             hit;
  logic             is_first;

  always_comb begin
    in_use   = lfmt_pkg::cmp_t'(cell_index) < lfmt_pkg::cmp_t'(tok_q.limit);
    is_first = (cell_index == '0);
    hit = tok_valid && !tok_q.done &&
          (((tok_q.kind == lfmt_pkg::TOK_FILL) && (tok_q.target == cell_index)) ||
           ((tok_q.kind == lfmt_pkg::TOK_REPL) && in_use &&
            (tok_q.distance <= slot_distance)));
    emit = tok_valid && (tok_q.kind == lfmt_pkg::TOK_READ) &&
           (in_use || (is_first && (tok_q.limit == '0)));

    tok_out       = tok_q;
    tok_out.done  = tok_q.done | hit;
    tok_out_valid = tok_valid;

    res = '0;
    if (emit) begin
      res.entry_index    = lfmt_pkg::entry_t'(cell_index);
      res.match_position = in_use ? slot_position : '0;
      res.match_distance = in_use ? slot_distance : '0;
      res.valid_res      = in_use;
      res.last           = in_use ? ((lfmt_pkg::cmp_t'(cell_index) + lfmt_pkg::cmp_t'(1))
                                     == lfmt_pkg::cmp_t'(tok_q.limit)) : 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid <= 1'b0;
    end else if (adv) begin
      tok_valid <= tok_in_valid;
    end
    if (adv) begin
      tok_q <= tok_in;
    end
    if (adv && hit) begin
      slot_position <= tok_q.pos;
      slot_distance <= tok_q.distance;
    end
  end

endmodule

>>> hw/rtl/l1_fingerprint_match_table.sv
`timescale 1ns / 1ps
// L1 fingerprint match table.
// Records, start commands and read-out commands arrive as transactions on the
// rec channel; results leave on the res channel; registers are written on the
// cfg channel, which is always ready. The table is a row of TABLE_DEPTH cells.
// A command travels along the row one cell per cycle unless the result output
// stalls, so the row holds one command at a time and rec_ready is high only
// while the row is empty. A record keeps the block busy while it is taken,
// passes the distance pipeline, is launched and crosses the row. The first
// result of a read-out is registered once the command has passed the launch
// register and the first cell; further results follow one per cycle while
// the receiver keeps up. A start command or an unused opcode produces nothing
// and leaves the block ready. When the receiver stalls, the result stays in
// the output register, and the row holds still while a cell waits to emit.
// Reset clears the fill count, the control state and the registers to their
// defaults; table contents are not cleared and are only ever reported after
// being written since the last start.
module l1_fingerprint_match_table (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               rec_valid,
  output logic                               rec_ready,
  input  lfmt_pkg::rec_t                     rec_data,
  output logic                               res_valid,
  input  logic                               res_ready,
  output lfmt_pkg::res_t                     res_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [lfmt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lfmt_pkg::CFG_DATA_W-1:0]    cfg_data
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIST,
    ST_LAUNCH,
    ST_RUN
  } state_t;

  state_t state;

  lfmt_pkg::count_t query_a;
  lfmt_pkg::count_t query_c;
  lfmt_pkg::count_t query_g;
  lfmt_pkg::count_t query_t;
  lfmt_pkg::dist_t  max_distance;
  lfmt_pkg::used_t  entries_in_use;

  lfmt_pkg::used_t  filled_count;
  lfmt_pkg::used_t  used;
  lfmt_pkg::used_t  read_count;
  lfmt_pkg::pos_t   pos_q;
  lfmt_pkg::dist_t  rec_distance;

  lfmt_pkg::token_t launch_tok;
  logic             launch_valid;

  lfmt_pkg::token_t tok_chain [lfmt_pkg::TABLE_DEPTH+1];
  logic             tok_chain_valid [lfmt_pkg::TABLE_DEPTH+1];
  logic             cell_emit [lfmt_pkg::TABLE_DEPTH];
  lfmt_pkg::res_t   cell_res [lfmt_pkg::TABLE_DEPTH];

  logic             any_emit;
  lfmt_pkg::res_t   emit_res;
  logic             adv;
  logic             rec_accept;

  assign cfg_ready  = 1'b1;
  assign rec_ready  = (state == ST_IDLE);
  assign rec_accept = rec_valid && rec_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      query_a        <= '0;
      query_c        <= '0;
      query_g        <= '0;
      query_t        <= '0;
      max_distance   <= lfmt_pkg::DEFAULT_MAX_DIST;
      entries_in_use <= lfmt_pkg::DEFAULT_ENTRIES;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        lfmt_pkg::CFG_QUERY_A:  query_a        <= lfmt_pkg::count_t'(cfg_data);
        lfmt_pkg::CFG_QUERY_C:  query_c        <= lfmt_pkg::count_t'(cfg_data);
        lfmt_pkg::CFG_QUERY_G:  query_g        <= lfmt_pkg::count_t'(cfg_data);
        lfmt_pkg::CFG_QUERY_T:  query_t        <= lfmt_pkg::count_t'(cfg_data);
        lfmt_pkg::CFG_MAX_DIST: max_distance   <= lfmt_pkg::dist_t'(cfg_data);
        lfmt_pkg::CFG_ENTRIES:  entries_in_use <= lfmt_pkg::used_t'(cfg_data);
        default: ;
      endcase
    end
  end

  always_comb begin
    used = (int'(entries_in_use) > lfmt_pkg::TABLE_DEPTH) ?
           lfmt_pkg::used_t'(lfmt_pkg::TABLE_DEPTH) : entries_in_use;
    read_count = (filled_count < used) ? filled_count : used;
  end

  lfmt_dist u_dist (
    .clk      (clk),
    .load     (rec_accept),
    .rec      (rec_data),
    .query_a  (query_a),
    .query_c  (query_c),
    .query_g  (query_g),
    .query_t  (query_t),
    .distance (rec_distance)
  );

  assign tok_chain[0]       = launch_tok;
  assign tok_chain_valid[0] = launch_valid;

  for (genvar i = 0; i < lfmt_pkg::TABLE_DEPTH; i++) begin : g_cell
    lfmt_cell u_cell (
      .clk           (clk),
      .rst           (rst),
      .adv           (adv),
      .cell_index    (lfmt_pkg::idx_t'(i)),
      .tok_in        (tok_chain[i]),
      .tok_in_valid  (tok_chain_valid[i]),
      .tok_out       (tok_chain[i+1]),
      .tok_out_valid (tok_chain_valid[i+1]),
      .emit          (cell_emit[i]),
      .res           (cell_res[i])
    );
  end

  always_comb begin
    any_emit = 1'b0;
    emit_res = '0;
    for (int i = 0; i < lfmt_pkg::TABLE_DEPTH; i++) begin
      any_emit = any_emit | cell_emit[i];
      emit_res = emit_res | cell_res[i];
    end
    adv = !any_emit || !res_valid || res_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      launch_valid <= 1'b0;
      filled_count <= '0;
      res_valid    <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (rec_valid) begin
            pos_q <= rec_data.position;
            unique case (rec_data.opcode)
              lfmt_pkg::OP_RECORD: state <= ST_DIST;
              lfmt_pkg::OP_START:  filled_count <= '0;
              lfmt_pkg::OP_READ: begin
                launch_tok.kind     <= lfmt_pkg::TOK_READ;
                launch_tok.done     <= 1'b0;
                launch_tok.target   <= '0;
                launch_tok.limit    <= read_count;
                launch_tok.distance <= '0;
                launch_tok.pos      <= '0;
                launch_valid        <= 1'b1;
                state               <= ST_RUN;
              end
              default: ;
            endcase
          end
        end
        ST_DIST: state <= ST_LAUNCH;
        ST_LAUNCH: begin
          launch_tok.limit    <= used;
          launch_tok.distance <= rec_distance;
          launch_tok.pos      <= pos_q;
          if (filled_count < used) begin
            launch_tok.kind   <= lfmt_pkg::TOK_FILL;
            launch_tok.done   <= 1'b0;
            launch_tok.target <= lfmt_pkg::idx_t'(filled_count);
            filled_count      <= filled_count + lfmt_pkg::used_t'(1);
          end else begin
            launch_tok.kind   <= lfmt_pkg::TOK_REPL;
            launch_tok.done   <= !(rec_distance <= max_distance);
            launch_tok.target <= '0;
          end
          launch_valid <= 1'b1;
          state        <= ST_RUN;
        end
        ST_RUN: begin
          if (adv) begin
            launch_valid <= 1'b0;
            if (tok_chain_valid[lfmt_pkg::TABLE_DEPTH]) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase

      if (adv && any_emit) begin
        res_valid <= 1'b1;
        res_data  <= emit_res;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

>>> hw/rtl/lfmt_checker.sv
`timescale 1ns / 1ps

module lfmt_checker (
  input logic           clk,
  input logic           rst,
  input logic           rec_valid,
  input logic           rec_ready,
  input lfmt_pkg::rec_t rec_data,
  input logic           res_valid,
  input logic           res_ready,
  input lfmt_pkg::res_t res_data
);

  // A stalled result must hold until it is taken.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_data))
    else $error("result changed while stalled");

  // A record transaction keeps the block busy for its walk along the table.
  a_record_busy: assert property (@(posedge clk) disable iff (rst)
    rec_valid && rec_ready && (rec_data.opcode == lfmt_pkg::OP_RECORD) |=> !rec_ready)
    else $error("block ready right after a record");

  // A start command completes at once.
  a_start_quick: assert property (@(posedge clk) disable iff (rst)
    rec_valid && rec_ready && (rec_data.opcode == lfmt_pkg::OP_START) |=> rec_ready)
    else $error("block busy after a start command");

  // The empty-table result is a single marked transaction with zero payload.
  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_data.valid_res |->
      res_data.last && (res_data.entry_index == '0) &&
      (res_data.match_position == '0) && (res_data.match_distance == '0))
    else $error("malformed empty-table result");

endmodule

bind l1_fingerprint_match_table lfmt_checker u_lfmt_checker (.*);

>>> tb/sv/lfmt_match_checker.sv
`timescale 1ns / 1ps

module lfmt_match_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               rec_valid,
  input  logic                               rec_ready,
  input  lfmt_pkg::rec_t                     rec_data,
  input  logic                               res_valid,
  input  logic                               res_ready,
  input  lfmt_pkg::res_t                     res_data,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [lfmt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lfmt_pkg::CFG_DATA_W-1:0]    cfg_data,
  output int                                 errors,
  output int                                 outstanding
);

  lfmt_pkg::pos_t   slot_pos [lfmt_pkg::TABLE_DEPTH];
  lfmt_pkg::dist_t  slot_dist [lfmt_pkg::TABLE_DEPTH];
  lfmt_pkg::used_t  filled;
  lfmt_pkg::count_t q_a, q_c, q_g, q_t;
  lfmt_pkg::dist_t  dist_limit;
  lfmt_pkg::used_t  entries;
  lfmt_pkg::res_t   expected_reports [$];
  int               reports_seen;

  task automatic report(string msg);
    errors++;
    if (errors <= 100) begin
      $display("ERROR at %0t: %s", $time, msg);
    end
  endtask

  function automatic int count_gap(lfmt_pkg::count_t x, lfmt_pkg::count_t y);
    return (x >= y) ? int'(x) - int'(y) : int'(y) - int'(x);
  endfunction

  function automatic lfmt_pkg::dist_t l1_distance(lfmt_pkg::rec_t r);
    int sum;
    sum = count_gap(r.count_a, q_a) + count_gap(r.count_c, q_c)
        + count_gap(r.count_g, q_g) + count_gap(r.count_t, q_t);
    return lfmt_pkg::dist_t'(sum);
  endfunction

  function automatic int slots_used();
    return (entries > lfmt_pkg::TABLE_DEPTH) ? lfmt_pkg::TABLE_DEPTH : int'(entries);
  endfunction

  task automatic apply_write(logic [lfmt_pkg::CFG_IDX_W-1:0] idx,
                             logic [lfmt_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      lfmt_pkg::CFG_QUERY_A:  q_a = data[lfmt_pkg::COUNT_W-1:0];
      lfmt_pkg::CFG_QUERY_C:  q_c = data[lfmt_pkg::COUNT_W-1:0];
      lfmt_pkg::CFG_QUERY_G:  q_g = data[lfmt_pkg::COUNT_W-1:0];
      lfmt_pkg::CFG_QUERY_T:  q_t = data[lfmt_pkg::COUNT_W-1:0];
      lfmt_pkg::CFG_MAX_DIST: dist_limit = data[lfmt_pkg::DIST_W-1:0];
      lfmt_pkg::CFG_ENTRIES:  entries = data[lfmt_pkg::USED_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_transaction(lfmt_pkg::rec_t r);
    int              used;
    int              n;
    bit              placed;
    lfmt_pkg::dist_t d;
    lfmt_pkg::res_t  rep;
    used = slots_used();
    case (r.opcode)
      lfmt_pkg::OP_RECORD: begin
        d = l1_distance(r);
        if (int'(filled) < used) begin
          slot_pos[lfmt_pkg::idx_t'(filled)]  = r.position;
          slot_dist[lfmt_pkg::idx_t'(filled)] = d;
          filled = filled + lfmt_pkg::used_t'(1);
        end else begin
          placed = 1'b0;
          for (int i = 0; i < used && !placed; i++) begin
            if (d <= slot_dist[i] && d <= dist_limit) begin
              slot_pos[i]  = r.position;
              slot_dist[i] = d;
              placed = 1'b1;
            end
          end
        end
      end
      lfmt_pkg::OP_START: filled = '0;
      lfmt_pkg::OP_READ: begin
        n = (int'(filled) < used) ? int'(filled) : used;
        if (n == 0) begin
          rep = '0;
          rep.last = 1'b1;
          expected_reports.push_back(rep);
        end else begin
          for (int k = 0; k < n; k++) begin
            rep.entry_index    = lfmt_pkg::entry_t'(k);
            rep.match_position = slot_pos[k];
            rep.match_distance = slot_dist[k];
            rep.valid_res      = 1'b1;
            rep.last           = (k == n - 1);
            expected_reports.push_back(rep);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic compare_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want) begin
      report($sformatf("result %0d: %s is %0h, expected %0h", reports_seen, name, got, want));
    end
  endtask

  task automatic check_report(lfmt_pkg::res_t got);
    lfmt_pkg::res_t want;
    reports_seen++;
    if (expected_reports.size() == 0) begin
      report($sformatf("result %0d arrived with none pending: %h", reports_seen, got));
      return;
    end
    want = expected_reports.pop_front();
    compare_field("entry_index", 64'(got.entry_index), 64'(want.entry_index));
    compare_field("match_position", 64'(got.match_position), 64'(want.match_position));
    compare_field("match_distance", 64'(got.match_distance), 64'(want.match_distance));
    compare_field("valid_res", 64'(got.valid_res), 64'(want.valid_res));
    compare_field("last", 64'(got.last), 64'(want.last));
  endtask

  // Results are checked before new work is applied, since a result taken at
  // the same edge as a new transaction always belongs to older work.
  always @(posedge clk) begin
    if (rst) begin
      q_a = '0;
      q_c = '0;
      q_g = '0;
      q_t = '0;
      dist_limit = lfmt_pkg::DEFAULT_MAX_DIST;
      entries = lfmt_pkg::DEFAULT_ENTRIES;
      filled = '0;
      for (int i = 0; i < lfmt_pkg::TABLE_DEPTH; i++) begin
        slot_pos[i]  = '0;
        slot_dist[i] = '0;
      end
      expected_reports.delete();
    end else begin
      if (res_valid && res_ready) begin
        check_report(res_data);
      end
      if (cfg_valid && cfg_ready) begin
        apply_write(cfg_index, cfg_data);
      end
      if (rec_valid && rec_ready) begin
        apply_transaction(rec_data);
      end
    end
    outstanding <= expected_reports.size();
  end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef logic [lfmt_pkg::CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [lfmt_pkg::CFG_DATA_W-1:0] cfg_data_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             rec_valid = 1'b0;
  logic             rec_ready;
  lfmt_pkg::rec_t   rec_data = '0;
  logic             res_valid;
  logic             res_ready = 1'b0;
  lfmt_pkg::res_t   res_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  cfg_idx_t         cfg_index = '0;
  cfg_data_t        cfg_data = '0;
  int               errors;
  int               outstanding;

  int               stall_left = 0;
  bit               gaps_on = 1'b1;
  bit               stalls_on = 1'b1;
  lfmt_pkg::count_t cur_q [4] = '{default: '0};
  lfmt_pkg::used_t  cur_entries = lfmt_pkg::DEFAULT_ENTRIES;
  int               spread = 0;
  int               random_items = 0;

  always #2 clk = ~clk;

  l1_fingerprint_match_table i_dut (.*);

  lfmt_match_checker i_checker (.*);

  function automatic int idle_len();
    if ($urandom_range(0, 9) < 8) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    if (stall_left > 0) begin
      res_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stalls_on && $urandom_range(0, 4) == 0) begin
      res_ready <= 1'b0;
      stall_left <= idle_len() - 1;
    end else begin
      res_ready <= 1'b1;
    end
  end

  function automatic lfmt_pkg::rec_t item(logic [1:0] op, lfmt_pkg::pos_t p,
                                          lfmt_pkg::count_t a, lfmt_pkg::count_t c,
                                          lfmt_pkg::count_t g, lfmt_pkg::count_t t);
    lfmt_pkg::rec_t x;
    x.opcode   = op;
    x.position = p;
    x.count_a  = a;
    x.count_c  = c;
    x.count_g  = g;
    x.count_t  = t;
    return x;
  endfunction

  function automatic lfmt_pkg::rec_t command(logic [1:0] op);
    return item(op, $urandom, lfmt_pkg::count_t'($urandom), lfmt_pkg::count_t'($urandom),
                lfmt_pkg::count_t'($urandom), lfmt_pkg::count_t'($urandom));
  endfunction

  task automatic send(lfmt_pkg::rec_t r);
    int g;
    g = (gaps_on && $urandom_range(0, 3) == 0) ? idle_len() : 0;
    if (g > 0) begin
      rec_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    rec_valid <= 1'b1;
    rec_data <= r;
    do @(posedge clk); while (!rec_ready);
  endtask

  task automatic write_reg(cfg_idx_t idx, cfg_data_t data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      lfmt_pkg::CFG_QUERY_A: cur_q[0] = data[lfmt_pkg::COUNT_W-1:0];
      lfmt_pkg::CFG_QUERY_C: cur_q[1] = data[lfmt_pkg::COUNT_W-1:0];
      lfmt_pkg::CFG_QUERY_G: cur_q[2] = data[lfmt_pkg::COUNT_W-1:0];
      lfmt_pkg::CFG_QUERY_T: cur_q[3] = data[lfmt_pkg::COUNT_W-1:0];
      lfmt_pkg::CFG_ENTRIES: cur_entries = data[lfmt_pkg::USED_W-1:0];
      default: ;
    endcase
  endtask

  // A record leaves no result behind, so the table may still be busy with one
  // after the last read-out result; the extra cycles cover its trip.
  task automatic wait_idle();
    rec_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (lfmt_pkg::TABLE_DEPTH + 8) @(posedge clk);
  endtask

  task automatic random_phase();
    cfg_idx_t         query_regs [4];
    cfg_data_t        data;
    lfmt_pkg::count_t cnt [4];
    int               mode;
    int               used;
    int               n;
    int               r;
    query_regs = '{lfmt_pkg::CFG_QUERY_A, lfmt_pkg::CFG_QUERY_C,
                   lfmt_pkg::CFG_QUERY_G, lfmt_pkg::CFG_QUERY_T};
    wait_idle();
    gaps_on = ($urandom_range(0, 4) != 0);
    stalls_on = ($urandom_range(0, 4) != 0);
    case ($urandom_range(0, 3))
      0: spread = 0;
      1: spread = 20;
      2: spread = 500;
      default: spread = 8000;
    endcase
    mode = $urandom_range(0, 5);
    for (int j = 0; j < 4; j++) begin
      if ($urandom_range(0, 9) < 7) begin
        data = cfg_data_t'($urandom);
        data[lfmt_pkg::COUNT_W-1:0] = (mode == 0) ? '0 : (mode == 1) ? '1 :
                                      lfmt_pkg::count_t'($urandom);
        write_reg(query_regs[j], data);
      end
    end
    if ($urandom_range(0, 9) < 7) begin
      case ($urandom_range(0, 5))
        0: data = '0;
        1: data = '1;
        2: data = cfg_data_t'($urandom);
        default: data = cfg_data_t'($urandom_range(0, 4 * spread + 1));
      endcase
      write_reg(lfmt_pkg::CFG_MAX_DIST, data);
    end
    if ($urandom_range(0, 9) < 7) begin
      data = cfg_data_t'($urandom);
      case ($urandom_range(0, 9))
        0: data[lfmt_pkg::USED_W-1:0] = lfmt_pkg::used_t'(0);
        1: data[lfmt_pkg::USED_W-1:0] = lfmt_pkg::used_t'(1);
        2: data[lfmt_pkg::USED_W-1:0] = lfmt_pkg::used_t'(lfmt_pkg::TABLE_DEPTH);
        3: data[lfmt_pkg::USED_W-1:0] =
             lfmt_pkg::used_t'($urandom_range(lfmt_pkg::TABLE_DEPTH + 1, 31));
        default: data[lfmt_pkg::USED_W-1:0] =
                   lfmt_pkg::used_t'($urandom_range(1, lfmt_pkg::TABLE_DEPTH));
      endcase
      write_reg(lfmt_pkg::CFG_ENTRIES, data);
    end
    if ($urandom_range(0, 19) == 0) begin
      write_reg(cfg_idx_t'(lfmt_pkg::CFG_ENTRIES + 1 + $urandom_range(0, 1)),
                cfg_data_t'($urandom));
    end
    cfg_valid <= 1'b0;

    used = (cur_entries > lfmt_pkg::TABLE_DEPTH) ? lfmt_pkg::TABLE_DEPTH : int'(cur_entries);
    if ($urandom_range(0, 4) != 0) begin
      send(command(lfmt_pkg::OP_START));
      random_items++;
    end
    n = $urandom_range(0, used + 12);
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        send(command(lfmt_pkg::OP_READ));
        random_items++;
      end else if (r < 7) begin
        send(command(OP_UNUSED));
      end else if (r < 9) begin
        send(command(lfmt_pkg::OP_START));
        random_items++;
      end
      for (int j = 0; j < 4; j++) begin
        if ($urandom_range(0, 4) == 0) begin
          cnt[j] = lfmt_pkg::count_t'($urandom);
        end else begin
          cnt[j] = lfmt_pkg::count_t'(int'(cur_q[j]) + int'($urandom_range(0, 2 * spread))
                                      - spread);
        end
      end
      send(item(lfmt_pkg::OP_RECORD, $urandom, cnt[0], cnt[1], cnt[2], cnt[3]));
      random_items++;
    end
    send(command(lfmt_pkg::OP_READ));
    random_items++;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send(command(lfmt_pkg::OP_READ));
    send(command(OP_UNUSED));
    send(command(lfmt_pkg::OP_START));
    send(item(lfmt_pkg::OP_RECORD, '0, '0, '0, '0, '0));
    send(item(lfmt_pkg::OP_RECORD, '1, '1, '1, '1, '1));
    send(item(lfmt_pkg::OP_RECORD, 32'h8000_0001, 16'h8000, 16'h0001, 16'h7FFF, 16'h0000));
    send(command(lfmt_pkg::OP_READ));
    send(command(lfmt_pkg::OP_START));
    send(command(lfmt_pkg::OP_READ));

    wait_idle();
    write_reg(lfmt_pkg::CFG_QUERY_A, '1);
    write_reg(lfmt_pkg::CFG_QUERY_C, '1);
    write_reg(lfmt_pkg::CFG_QUERY_G, '1);
    write_reg(lfmt_pkg::CFG_QUERY_T, '1);
    write_reg(lfmt_pkg::CFG_MAX_DIST, '0);
    write_reg(lfmt_pkg::CFG_ENTRIES, 18'd1);
    cfg_valid <= 1'b0;
    send(command(lfmt_pkg::OP_START));
    send(item(lfmt_pkg::OP_RECORD, 32'd1, '1, '1, '1, '1));
    send(item(lfmt_pkg::OP_RECORD, 32'd2, '0, '0, '0, '0));
    send(item(lfmt_pkg::OP_RECORD, 32'd3, '1, '1, '1, '1));
    send(command(lfmt_pkg::OP_READ));

    wait_idle();
    write_reg(lfmt_pkg::CFG_ENTRIES, 18'd0);
    cfg_valid <= 1'b0;
    send(item(lfmt_pkg::OP_RECORD, 32'd4, '1, '1, '1, '1));
    send(command(lfmt_pkg::OP_READ));

    wait_idle();
    write_reg(lfmt_pkg::CFG_ENTRIES, '1);
    write_reg(lfmt_pkg::CFG_MAX_DIST, '1);
    cfg_valid <= 1'b0;
    send(command(lfmt_pkg::OP_READ));
    send(item(lfmt_pkg::OP_RECORD, 32'd5, '0, '0, '0, '0));
    send(command(lfmt_pkg::OP_READ));

    while (random_items < 250) begin
      random_phase();
    end

    wait_idle();
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
